[design/fts_pkg.sv]
// Shared types, constants and helpers for the failover tier selector.
package fts_pkg;

   localparam int NUM_TIERS = 8;
   localparam int IDX_W     = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
   localparam int CNT_W     = 16;
   localparam int REQ_W     = 3;
   localparam int FAULT_W   = 3;
   localparam int AVAIL_W   = 8;
   localparam int OUT_IDX_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int DATA_W    = 16;

   localparam logic [CNT_W-1:0]   CNT_MAX       = '1;
   localparam logic [FAULT_W-1:0] FAULT_REMOVED = 3'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_QUAR_TICKS     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_INTERVAL = 1'd1;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK    = 3'd0,
      REQ_SELECT  = 3'd1,
      REQ_REPORT  = 3'd2,
      REQ_RECOVER = 3'd3,
      REQ_SESSION = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_SCAN_SELECT,
      CMD_SCAN_REPORT,
      CMD_SCAN_RECOVER,
      CMD_SESSION
   } cell_cmd_type;

   // Broadcast to every cell in the ladder.
   typedef struct packed {
      cell_cmd_type       cmd;
      logic [CNT_W-1:0]   quar_ticks;
      logic [CNT_W-1:0]   probe_interval;
      logic [FAULT_W-1:0] fault_code;
   } cell_bus_type;

   // Per-cell qualifiers worked out from the active tier and the probe bits.
   typedef struct packed {
      logic target;
      logic below_active;
      logic avail;
   } cell_ctrl_type;

   function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W+OUT_IDX_W-1:0] ext;
      ext = {{OUT_IDX_W{1'b0}}, idx};
      return ext[OUT_IDX_W-1:0];
   endfunction

endpackage

[design/fts_cell.sv]
// One tier of the ladder: its health, quarantine and fault state plus its link in the scan chain.
module fts_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  fts_pkg::cell_bus_type  bus,
   input  fts_pkg::cell_ctrl_type ctrl,
   input  logic                 claim_in,
   output logic                 claim_out,
   output logic                 claim
);
   import fts_pkg::*;

   logic             fatal_ff, fatal_in;
   logic [CNT_W-1:0] quar_ff, quar_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             cache_ok_ff, cache_ok_in;
   logic             cached_ff, cached_in;
   logic [CNT_W-1:0] age_ff, age_in;

   logic             rep_here;
   logic             fatal_eff;
   logic [CNT_W-1:0] quar_eff;
   logic             cache_eff;
   logic             scan;
   logic             check;
   logic             use_cache;
   logic             health;

   // A fault report on this tier takes effect before the scan looks at it.
   assign rep_here  = (bus.cmd == CMD_SCAN_REPORT) && ctrl.target;
   assign fatal_eff = fatal_ff | (rep_here && (bus.fault_code == FAULT_REMOVED));
   assign quar_eff  = rep_here ? bus.quar_ticks : quar_ff;
   assign cache_eff = cache_ok_ff & ~rep_here;

   assign scan = (bus.cmd == CMD_SCAN_SELECT) || (bus.cmd == CMD_SCAN_REPORT) ||
                 ((bus.cmd == CMD_SCAN_RECOVER) && ctrl.below_active && (count_ff != '0));

   // Only tiers the scan actually reaches run a health check.
   assign check     = scan && !claim_in && !fatal_eff && (quar_eff == '0);
   assign use_cache = (bus.probe_interval != '0) && cache_eff && (age_ff < bus.probe_interval);
   assign health    = use_cache ? cached_ff : ctrl.avail;
   assign claim     = check && health;
   assign claim_out = claim_in | claim;

   always_comb begin
      fatal_in    = fatal_ff;
      quar_in     = quar_ff;
      count_in    = count_ff;
      cache_ok_in = cache_ok_ff;
      cached_in   = cached_ff;
      age_in      = age_ff;
      case (bus.cmd)
         CMD_TICK: begin
            if (quar_ff != '0) quar_in = quar_ff - 1'b1;
            if (age_ff != CNT_MAX) age_in = age_ff + 1'b1;
         end
         CMD_SESSION: begin
            fatal_in    = 1'b0;
            quar_in     = '0;
            cache_ok_in = 1'b0;
         end
         default: begin
            if (rep_here) begin
               fatal_in    = fatal_eff;
               quar_in     = quar_eff;
               cache_ok_in = 1'b0;
               if (count_ff != CNT_MAX) count_in = count_ff + 1'b1;
            end
            if (check && !use_cache) begin
               cached_in   = ctrl.avail;
               age_in      = '0;
               cache_ok_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fatal_ff    <= 1'b0;
         quar_ff     <= '0;
         count_ff    <= '0;
         cache_ok_ff <= 1'b0;
         cached_ff   <= 1'b0;
         age_ff      <= '0;
      end else begin
         fatal_ff    <= fatal_in;
         quar_ff     <= quar_in;
         count_ff    <= count_in;
         cache_ok_ff <= cache_ok_in;
         cached_ff   <= cached_in;
         age_ff      <= age_in;
      end
   end

endmodule

[design/failover_tier_selector.sv]
// Top level of the failover tier selector: request decode, ladder of tier cells, result register.
//
//   channel  direction  handshake          payload
//   req      in         tvalid / tready    tdata: fault_code, probe_avail; tuser: req_type
//   rsp      out        tvalid / tready    tdata: ok, active, baseline, reason fields
//   csr      in         we                 index, wdata (16 bits)
//
// Each request is first captured and then executed in a scan step in which the whole
// ladder scans and updates, the tier cells passing the claim down the chain.
// The result sits in an output register, so the next request is taken while it waits;
// if the previous result is still unread the scan cycle waits for it.
// Reset is synchronous and brings every tier and the selection state to zero.
module failover_tier_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // fault_code [2:0], probe_avail [10:3], zero fill
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ok, active_valid, active_index, baseline_valid,
                                    // baseline_index, reason_valid, reason_tier, reason_fault
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   req_kind_type       kind_ff;
   logic [FAULT_W-1:0] fault_ff;
   logic [AVAIL_W-1:0] avail_ff;

   logic [CNT_W-1:0]   quar_ticks_ff;
   logic [CNT_W-1:0]   probe_interval_ff;

   logic               active_flag_ff, active_flag_in;
   logic [IDX_W-1:0]   active_idx_ff, active_idx_in;
   logic               baseline_flag_ff, baseline_flag_in;
   logic [IDX_W-1:0]   baseline_idx_ff, baseline_idx_in;
   logic               reason_flag_ff, reason_flag_in;
   logic [IDX_W-1:0]   reason_idx_ff, reason_idx_in;
   logic [FAULT_W-1:0] reason_code_ff, reason_code_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               fire;
   logic               ok;
   cell_cmd_type       cmd;
   cell_bus_type       bus;
   cell_ctrl_type      ctrl [NUM_TIERS];
   logic [NUM_TIERS:0] chain;
   logic [NUM_TIERS-1:0] claim;
   logic               any;
   logic [IDX_W-1:0]   found;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign fire       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      cmd = CMD_NONE;
      if (fire) begin
         case (kind_ff)
            REQ_TICK:    cmd = CMD_TICK;
            REQ_SELECT:  cmd = CMD_SCAN_SELECT;
            REQ_REPORT:  cmd = active_flag_ff ? CMD_SCAN_REPORT : CMD_NONE;
            REQ_RECOVER: cmd = (active_flag_ff && (active_idx_ff != '0)) ?
                               CMD_SCAN_RECOVER : CMD_NONE;
            REQ_SESSION: cmd = CMD_SESSION;
            default:     cmd = CMD_NONE;
         endcase
      end
   end

   assign bus.cmd            = cmd;
   assign bus.quar_ticks     = quar_ticks_ff;
   assign bus.probe_interval = probe_interval_ff;
   assign bus.fault_code     = fault_ff;

   assign chain[0] = 1'b0;

   for (genvar gi = 0; gi < NUM_TIERS; gi++) begin : g_tier
      assign ctrl[gi].target       = (active_idx_ff == IDX_W'(gi));
      assign ctrl[gi].below_active = (IDX_W'(gi) < active_idx_ff);
      if (gi < AVAIL_W) begin : g_probe
         assign ctrl[gi].avail = avail_ff[gi];
      end else begin : g_no_probe
         assign ctrl[gi].avail = 1'b0;
      end

      fts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bus       (bus),
         .ctrl      (ctrl[gi]),
         .claim_in  (chain[gi]),
         .claim_out (chain[gi+1]),
         .claim     (claim[gi])
      );
   end

   assign any = chain[NUM_TIERS];

   // At most one cell claims, so OR-ing the indices encodes the winner.
   always_comb begin
      found = '0;
      for (int i = 0; i < NUM_TIERS; i++) begin
         if (claim[i]) found = found | IDX_W'(i);
      end
   end

   always_comb begin
      active_flag_in   = active_flag_ff;
      active_idx_in    = active_idx_ff;
      baseline_flag_in = baseline_flag_ff;
      baseline_idx_in  = baseline_idx_ff;
      reason_flag_in   = reason_flag_ff;
      reason_idx_in    = reason_idx_ff;
      reason_code_in   = reason_code_ff;
      ok               = 1'b0;
      case (cmd)
         CMD_TICK, CMD_SESSION: begin
            ok = 1'b1;
         end
         CMD_SCAN_SELECT, CMD_SCAN_REPORT: begin
            if (any) begin
               active_flag_in = 1'b1;
               active_idx_in  = found;
               if (!baseline_flag_ff) begin
                  baseline_flag_in = 1'b1;
                  baseline_idx_in  = found;
               end
               if (found <= baseline_idx_in) reason_flag_in = 1'b0;
               ok = 1'b1;
            end else begin
               active_flag_in = 1'b0;
            end
            if (cmd == CMD_SCAN_REPORT) begin
               // Falling back only counts when a lower tier took over.
               if (!any || (found <= active_idx_ff)) begin
                  active_flag_in = 1'b1;
                  active_idx_in  = active_idx_ff;
                  ok             = 1'b0;
               end else begin
                  reason_flag_in = 1'b1;
                  reason_idx_in  = active_idx_ff;
                  reason_code_in = fault_ff;
                  ok             = 1'b1;
               end
            end
         end
         CMD_SCAN_RECOVER: begin
            if (any) begin
               active_idx_in = found;
               if (found <= baseline_idx_ff) reason_flag_in = 1'b0;
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {reason_code_in, to_out_idx(reason_idx_in), reason_flag_in,
                     to_out_idx(baseline_idx_in), baseline_flag_in,
                     to_out_idx(active_idx_in), active_flag_in, ok};
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         quar_ticks_ff     <= '0;
         probe_interval_ff <= '0;
         active_flag_ff    <= 1'b0;
         active_idx_ff     <= '0;
         baseline_flag_ff  <= 1'b0;
         baseline_idx_ff   <= '0;
         reason_flag_ff    <= 1'b0;
         reason_idx_ff     <= '0;
         reason_code_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_QUAR_TICKS:     quar_ticks_ff     <= csr_wdata;
               CSR_PROBE_INTERVAL: probe_interval_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            active_flag_ff   <= active_flag_in;
            active_idx_ff    <= active_idx_in;
            baseline_flag_ff <= baseline_flag_in;
            baseline_idx_ff  <= baseline_idx_in;
            reason_flag_ff   <= reason_flag_in;
            reason_idx_ff    <= reason_idx_in;
            reason_code_ff   <= reason_code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind_type'(req_tuser);
         fault_ff <= req_tdata[FAULT_W-1:0];
         avail_ff <= req_tdata[FAULT_W+AVAIL_W-1:FAULT_W];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[verif/failover_tier_selector_tb.sv]
// Self-checking testbench for the failover tier selector, with a predicting scoreboard.
module failover_tier_selector_tb;
   import fts_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 170;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE       = 4;

   localparam logic [FAULT_W-1:0] FAULT_NONE        = 3'd0;
   localparam logic [FAULT_W-1:0] FAULT_UNAVAILABLE = 3'd1;
   localparam logic [FAULT_W-1:0] FAULT_UNSUPPORTED = 3'd3;
   localparam logic [FAULT_W-1:0] FAULT_RUNTIME     = 3'd4;
   localparam logic [REQ_W-1:0]   FIRST_UNDEFINED_REQ = REQ_SESSION + 3'd1;

   // Result word, lowest field in the lowest bits.
   typedef struct packed {
      logic [2:0] reason_fault;
      logic [2:0] reason_tier;
      logic       reason_valid;
      logic [2:0] baseline_index;
      logic       baseline_valid;
      logic [2:0] active_index;
      logic       active_valid;
      logic       ok;
   } ladder_status_type;

   class ladder_scoreboard;
      bit [CNT_W-1:0]   quar_ticks;
      bit [CNT_W-1:0]   probe_interval;
      bit               active_flag;
      bit [IDX_W-1:0]   active_idx;
      bit               baseline_flag;
      bit [IDX_W-1:0]   baseline_idx;
      bit               reason_flag;
      bit [IDX_W-1:0]   reason_idx;
      bit [FAULT_W-1:0] reason_code;
      bit               fatal [NUM_TIERS];
      bit [CNT_W-1:0]   quar_left [NUM_TIERS];
      bit [CNT_W-1:0]   fault_count [NUM_TIERS];
      bit               cache_ok [NUM_TIERS];
      bit               cached_health [NUM_TIERS];
      bit [CNT_W-1:0]   probe_age [NUM_TIERS];
      ladder_status_type expected_status [$];
      int               mismatches;
      int               results_checked;

      function new();
         quar_ticks = '0;
         probe_interval = '0;
         active_flag = 1'b0;
         active_idx = '0;
         baseline_flag = 1'b0;
         baseline_idx = '0;
         reason_flag = 1'b0;
         reason_idx = '0;
         reason_code = '0;
         for (int i = 0; i < NUM_TIERS; i++) begin
            fatal[i] = 1'b0;
            quar_left[i] = '0;
            fault_count[i] = '0;
            cache_ok[i] = 1'b0;
            cached_health[i] = 1'b0;
            probe_age[i] = '0;
         end
         mismatches = 0;
         results_checked = 0;
      endfunction

      function void set_registers(bit [CNT_W-1:0] quar, bit [CNT_W-1:0] interval);
         quar_ticks = quar;
         probe_interval = interval;
      endfunction

      // A cached health result is reused only while it is younger than the interval.
      function bit health_ok(int i, logic [AVAIL_W-1:0] avail);
         if (probe_interval != 0 && cache_ok[i] && probe_age[i] < probe_interval)
            return cached_health[i];
         cached_health[i] = (i < AVAIL_W) ? avail[i] : 1'b0;
         probe_age[i] = '0;
         cache_ok[i] = 1'b1;
         return cached_health[i];
      endfunction

      function bit try_select(logic [AVAIL_W-1:0] avail);
         for (int i = 0; i < NUM_TIERS; i++) begin
            if (fatal[i] || quar_left[i] != 0)
               continue;
            if (!health_ok(i, avail))
               continue;
            active_idx = IDX_W'(i);
            active_flag = 1'b1;
            if (!baseline_flag) begin
               baseline_idx = IDX_W'(i);
               baseline_flag = 1'b1;
            end
            if (active_idx <= baseline_idx)
               reason_flag = 1'b0;
            return 1'b1;
         end
         active_flag = 1'b0;
         return 1'b0;
      endfunction

      function bit report_fault(logic [FAULT_W-1:0] fault, logic [AVAIL_W-1:0] avail);
         bit [IDX_W-1:0] prev;
         if (!active_flag)
            return 1'b0;
         prev = active_idx;
         cache_ok[prev] = 1'b0;
         if (fault_count[prev] != CNT_MAX)
            fault_count[prev]++;
         quar_left[prev] = quar_ticks;
         if (fault == FAULT_REMOVED)
            fatal[prev] = 1'b1;
         // A fallback that fails or does not move down restores the faulted tier.
         if (!try_select(avail) || active_idx <= prev) begin
            active_idx = prev;
            active_flag = 1'b1;
            return 1'b0;
         end
         reason_flag = 1'b1;
         reason_idx = prev;
         reason_code = fault;
         return 1'b1;
      endfunction

      function bit try_recover(logic [AVAIL_W-1:0] avail);
         if (!active_flag || active_idx == 0)
            return 1'b0;
         for (int i = 0; i < active_idx; i++) begin
            if (fault_count[i] == 0)
               continue;
            if (fatal[i] || quar_left[i] != 0)
               continue;
            if (!health_ok(i, avail))
               continue;
            active_idx = IDX_W'(i);
            if (active_idx <= baseline_idx)
               reason_flag = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [FAULT_W-1:0] fault,
                                 logic [AVAIL_W-1:0] avail);
         ladder_status_type status;
         bit done;
         case (kind)
            REQ_TICK: begin
               for (int i = 0; i < NUM_TIERS; i++) begin
                  if (quar_left[i] != 0)
                     quar_left[i]--;
                  if (probe_age[i] != CNT_MAX)
                     probe_age[i]++;
               end
               done = 1'b1;
            end
            REQ_SELECT:  done = try_select(avail);
            REQ_REPORT:  done = report_fault(fault, avail);
            REQ_RECOVER: done = try_recover(avail);
            REQ_SESSION: begin
               for (int i = 0; i < NUM_TIERS; i++) begin
                  fatal[i] = 1'b0;
                  quar_left[i] = '0;
                  cache_ok[i] = 1'b0;
               end
               done = 1'b1;
            end
            default: done = 1'b0;
         endcase
         status.ok             = done;
         status.active_valid   = active_flag;
         status.active_index   = 3'(active_idx);
         status.baseline_valid = baseline_flag;
         status.baseline_index = 3'(baseline_idx);
         status.reason_valid   = reason_flag;
         status.reason_tier    = 3'(reason_idx);
         status.reason_fault   = 3'(reason_code);
         expected_status = {expected_status, status};
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [2:0] got, logic [2:0] want);
         if (got !== want)
            report($sformatf("result %0d: %s is %0d, predicted %0d",
                             results_checked, name, got, want));
      endtask

      task check_result(ladder_status_type got);
         ladder_status_type want;
         results_checked++;
         if (expected_status.size() == 0) begin
            report($sformatf("result %h arrived with no request pending", got));
            return;
         end
         want = expected_status.pop_front();
         compare_field("ok", 3'(got.ok), 3'(want.ok));
         compare_field("active_valid", 3'(got.active_valid), 3'(want.active_valid));
         compare_field("active_index", got.active_index, want.active_index);
         compare_field("baseline_valid", 3'(got.baseline_valid), 3'(want.baseline_valid));
         compare_field("baseline_index", got.baseline_index, want.baseline_index);
         compare_field("reason_valid", 3'(got.reason_valid), 3'(want.reason_valid));
         compare_field("reason_tier", got.reason_tier, want.reason_tier);
         compare_field("reason_fault", got.reason_fault, want.reason_fault);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // fault_code [2:0], probe_avail [10:3], zero fill
   logic [2:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // ok, active_valid, active_index, baseline_valid,
                                  // baseline_index, reason_valid, reason_tier, reason_fault
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   ladder_scoreboard sb = new();

   failover_tier_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Valid is left high after acceptance, so back-to-back requests keep it asserted between them.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [FAULT_W-1:0] fault,
                               input logic [AVAIL_W-1:0] avail);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= 16'({avail, fault});
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, fault, avail);
   endtask

   task automatic send_random_request();
      logic [REQ_W-1:0]   kind;
      logic [FAULT_W-1:0] fault;
      logic [AVAIL_W-1:0] avail;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         kind = REQ_TICK;
      else if (pick < 52)
         kind = REQ_SELECT;
      else if (pick < 74)
         kind = REQ_REPORT;
      else if (pick < 88)
         kind = REQ_RECOVER;
      else if (pick < 95)
         kind = REQ_SESSION;
      else
         kind = FIRST_UNDEFINED_REQ + REQ_W'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 6)
         fault = FAULT_UNAVAILABLE + FAULT_W'($urandom_range(0, 3));
      else
         fault = FAULT_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0:       avail = '1;
         1:       avail = AVAIL_W'($urandom);
         2:       avail = AVAIL_W'($urandom | $urandom);
         default: avail = ~(AVAIL_W'(1) << $urandom_range(0, 7));
      endcase
      send_request(kind, fault, avail);
   endtask

   task automatic write_registers(input logic [CNT_W-1:0] quar, input logic [CNT_W-1:0] interval);
      csr_we    <= 1'b1;
      csr_index <= CSR_QUAR_TICKS;
      csr_wdata <= quar;
      @(posedge clock);
      csr_index <= CSR_PROBE_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_registers(quar, interval);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CNT_W-1:0] quar, input logic [CNT_W-1:0] interval);
      drain();
      write_registers(quar, interval);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 32 == 0)
            req_burst = ($urandom_range(0, 3) == 0);
         send_random_request();
      end
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : rsp_side
      int gap;
      int hold_points [$];
      hold_points = '{250, 600, 900};
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 7);
         // Long hold-offs let the output register and the input stage fill up.
         if (hold_points.size() != 0 && sb.results_checked >= hold_points[0]) begin
            void'(hold_points.pop_front());
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
         if (sb.results_checked % 64 == 0)
            rsp_burst = ~rsp_burst;
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_registers(16'd2, 16'd0);

      // Directed part: empty ladder, fallback, fatal removal, recovery, session reset and undefined request kinds.
      send_request(REQ_RECOVER, FAULT_NONE, 8'hFF);
      send_request(REQ_REPORT, FAULT_UNAVAILABLE, 8'hFF);
      send_request(REQ_SELECT, FAULT_NONE, 8'h00);
      send_request(REQ_SELECT, FAULT_NONE, 8'hFE);
      send_request(REQ_SELECT, FAULT_NONE, 8'hFF);
      send_request(REQ_RECOVER, FAULT_NONE, 8'hFF);
      send_request(REQ_REPORT, FAULT_UNAVAILABLE, 8'hFF);
      send_request(REQ_REPORT, FAULT_REMOVED, 8'h04);
      send_request(REQ_RECOVER, FAULT_NONE, 8'hFF);
      send_request(REQ_TICK, FAULT_NONE, 8'h00);
      send_request(REQ_TICK, FAULT_NONE, 8'hFF);
      send_request(REQ_RECOVER, FAULT_NONE, 8'hFF);
      send_request(REQ_REPORT, FAULT_RUNTIME, 8'h00);
      send_request(REQ_REPORT, FAULT_RUNTIME + 3'd3, 8'h80);
      send_request(REQ_SELECT, FAULT_NONE, 8'h00);
      send_request(REQ_SESSION, FAULT_NONE, 8'h00);
      send_request(REQ_SELECT, FAULT_NONE, 8'hFF);
      send_request(FIRST_UNDEFINED_REQ, FAULT_REMOVED, 8'hFF);
      send_request(FIRST_UNDEFINED_REQ + 3'd1, FAULT_NONE, 8'h55);
      send_request(FIRST_UNDEFINED_REQ + 3'd2, FAULT_RUNTIME, 8'hAA);
      send_request(REQ_REPORT, FAULT_NONE, 8'hFF);
      send_request(REQ_REPORT, FAULT_UNSUPPORTED, 8'hFF);
      send_request(REQ_REPORT, FAULT_RUNTIME + 3'd1, 8'h00);
      send_request(REQ_TICK, FAULT_NONE, 8'h00);

      run_phase(16'd0, 16'd0);
      run_phase(16'd3, 16'd2);
      run_phase(CNT_MAX, CNT_MAX);
      run_phase(16'd1, 16'd1);
      run_phase(16'd6, 16'd4);
      run_phase(CNT_MAX, 16'd0);

      drain();
      repeat (2 * SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_status.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
design/fts_pkg.sv
design/fts_cell.sv
design/failover_tier_selector.sv
verif/failover_tier_selector_tb.sv
